// ===== hdl/fuzzy_two_input_servo_controller_assert.svh =====
// ---------------------------------------------------------------------------
// Fuzzy two-input servo controller assertion macros
// Shorthand for clocked assertions; the same-cycle form is disabled during reset.
// ---------------------------------------------------------------------------
`ifndef FUZZY_TWO_INPUT_SERVO_CONTROLLER_ASSERT_SVH
`define FUZZY_TWO_INPUT_SERVO_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define FTSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: consequent did not hold in the same cycle");

// Next-cycle implication, also checked while reset is high.
`define FTSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: consequent did not hold one cycle later");

`endif

// ===== hdl/ftsc_pkg.sv =====
// ---------------------------------------------------------------------------
// Fuzzy servo controller package
// Widths, membership term corners, reciprocals and output codes.
// ---------------------------------------------------------------------------
package ftsc_pkg;

  localparam int FRAC = 15;          // fractional bits of a grade
  localparam int RSH  = 16;          // extra bits of reciprocal precision
  localparam int KW   = 9;           // offset from a foot, at most 300
  localparam int GW   = FRAC + 1;    // grade, 1.0 included
  localparam int RW   = FRAC + RSH - 6;
  localparam int PW   = KW + RW;
  localparam int NUMW = KW + FRAC;
  localparam int WW   = GW + 4;      // sum of nine strengths
  localparam int SW   = GW + 12;     // sum of strength times centroid
  localparam int NW   = SW + 1;      // divider numerator
  localparam int QW   = 8;           // angle width
  localparam int NT   = 6;           // three temperature and three humidity terms

  localparam logic [17:0] RULE_RESET = 18'd170256;

  localparam logic [1:0] CODE_LOW = 2'd0;
  localparam logic [1:0] CODE_MED = 2'd1;

  localparam logic [7:0] CEN_LOW  = 8'd45;
  localparam logic [7:0] CEN_MED  = 8'd90;
  localparam logic [7:0] CEN_HIGH = 8'd135;

  localparam longint unsigned ONE = 64'd1 << (FRAC + RSH);
  localparam logic [RW-1:0] R100 = RW'(ONE / 64'd100);
  localparam logic [RW-1:0] R150 = RW'(ONE / 64'd150);
  localparam logic [RW-1:0] R200 = RW'(ONE / 64'd200);
  localparam logic [RW-1:0] R300 = RW'(ONE / 64'd300);

  // Terms 0..2 grade temperature, terms 3..5 grade humidity.
  localparam logic signed [11:0] TERM_A [NT] =
    '{-12'sd200, 12'sd100, 12'sd300, 12'sd0, 12'sd400, 12'sd700};
  localparam logic signed [11:0] TERM_B [NT] =
    '{12'sd0, 12'sd250, 12'sd500, 12'sd300, 12'sd600, 12'sd900};
  localparam logic signed [11:0] TERM_C [NT] =
    '{12'sd200, 12'sd400, 12'sd700, 12'sd600, 12'sd800, 12'sd1000};

  localparam logic [KW-1:0] DIV_RISE [NT] =
    '{9'd200, 9'd150, 9'd200, 9'd300, 9'd200, 9'd200};
  localparam logic [KW-1:0] DIV_FALL [NT] =
    '{9'd200, 9'd150, 9'd200, 9'd300, 9'd200, 9'd100};
  localparam logic [RW-1:0] REC_RISE [NT] = '{R200, R150, R200, R300, R200, R200};
  localparam logic [RW-1:0] REC_FALL [NT] = '{R200, R150, R200, R300, R200, R100};

endpackage

// ===== hdl/fuzzy_two_input_servo_controller.sv =====
// ---------------------------------------------------------------------------
// Fuzzy two-input servo controller
// Grades a temperature and humidity pair, fires nine min rules and returns
// the strength-weighted centroid angle.
// ---------------------------------------------------------------------------
// The block accepts one temperature / humidity word per cycle while the output
// side does not stall, and returns one angle word for each, in order. Stages
// 1 to 3 grade both samples against their three triangular terms
// (offset select, reciprocal multiply, one-step remainder correction), stage 4
// takes the nine rule strengths and their centroid products, stage 5 sums
// them, and eight restoring divider stages, one quotient bit each, form the
// rounded average. The whole pipeline advances together whenever the output
// register is empty or being taken, so throughput is one word per cycle.
// The rule table may be rewritten only while the block is idle; cfg_ready is
// always high.
`include "fuzzy_two_input_servo_controller_assert.svh"

module fuzzy_two_input_servo_controller import ftsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [10:0] temperature, [20:11] humidity
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] servo_angle
  output logic        m_tuser,   // [0] no_rule_fired
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [17:0] cfg_data
);

  logic [17:0] rule_table;

  // Pipeline advance: every stage moves when the output register frees up.
  logic adv;

  // Stage 1: offset from the active foot.
  logic          v1;
  logic [KW-1:0] k1 [NT];
  logic          fall1 [NT];
  logic          z1 [NT];
  // Stage 2: reciprocal product.
  logic          v2;
  logic [PW-1:0] p2 [NT];
  logic [KW-1:0] k2 [NT];
  logic          fall2 [NT];
  logic          z2 [NT];
  // Stage 3: grades.
  logic          v3;
  logic [GW-1:0] g3 [NT];
  // Stage 4: rule strengths and weighted strengths.
  logic            v4;
  logic [GW-1:0]   s4 [9];
  logic [GW+7:0]   sp4 [9];
  // Stage 5: sums.
  logic          v5;
  logic [WW-1:0] w5;
  logic [SW-1:0] s5;
  // Divider stages.
  logic          dv [QW+1];
  logic [NW-1:0] drem [QW+1];
  logic [NW-1:0] dden [QW+1];
  logic [QW-1:0] dq [QW+1];
  logic          dz [QW+1];

  logic signed [11:0] temp_x;
  logic signed [11:0] hum_x;

  assign temp_x    = 12'(signed'(s_tdata[10:0]));
  assign hum_x     = signed'({2'b00, s_tdata[20:11]});
  assign adv       = !dv[QW] || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = dv[QW];
  assign m_tdata   = dz[QW] ? '0 : dq[QW];
  assign m_tuser   = dz[QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_table <= RULE_RESET;
    end else if (cfg_valid) begin
      rule_table <= cfg_data;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      for (int j = 0; j <= QW; j++) begin
        dv[j] <= 1'b0;
      end
    end else if (adv) begin
      v1    <= s_tvalid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      dv[0] <= v5;
      for (int j = 0; j < QW; j++) begin
        dv[j+1] <= dv[j];
      end
    end
  end

  // Grading stages.
  always_ff @(posedge clk) begin
    logic signed [11:0] x;
    logic signed [11:0] off;
    logic [GW-1:0]      q0;
    logic [KW-1:0]      d;
    logic [NUMW-1:0]    rem;
    if (adv) begin
      for (int t = 0; t < NT; t++) begin
        x        = (t < 3) ? temp_x : hum_x;
        off      = (x <= TERM_B[t]) ? (x - TERM_A[t]) : (TERM_C[t] - x);
        k1[t]    <= off[KW-1:0];
        fall1[t] <= (x > TERM_B[t]);
        z1[t]    <= (x <= TERM_A[t]) || (x >= TERM_C[t]);

        p2[t]    <= PW'(k1[t]) * PW'(fall1[t] ? REC_FALL[t] : REC_RISE[t]);
        k2[t]    <= k1[t];
        fall2[t] <= fall1[t];
        z2[t]    <= z1[t];

        // The reciprocal product is low by at most one; fix it here.
        q0  = p2[t][RSH +: GW];
        d   = fall2[t] ? DIV_FALL[t] : DIV_RISE[t];
        rem = (NUMW'(k2[t]) << FRAC) - NUMW'(q0) * NUMW'(d);
        if (z2[t]) begin
          g3[t] <= '0;
        end else if (rem >= NUMW'(d)) begin
          g3[t] <= q0 + GW'(1);
        end else begin
          g3[t] <= q0;
        end
      end
    end
  end

  // Rules and sums.
  always_ff @(posedge clk) begin
    logic [GW-1:0] s;
    logic [1:0]    code;
    logic [7:0]    cen;
    logic [WW-1:0] wacc;
    logic [SW-1:0] sacc;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int h = 0; h < 3; h++) begin
          s    = (g3[i] < g3[3+h]) ? g3[i] : g3[3+h];
          code = rule_table[2*(3*i+h) +: 2];
          unique case (code)
            CODE_LOW: cen = CEN_LOW;
            CODE_MED: cen = CEN_MED;
            default:  cen = CEN_HIGH;
          endcase
          s4[3*i+h]  <= s;
          sp4[3*i+h] <= (GW+8)'(s) * (GW+8)'(cen);
        end
      end
      wacc = '0;
      sacc = '0;
      for (int r = 0; r < 9; r++) begin
        wacc = wacc + WW'(s4[r]);
        sacc = sacc + SW'(sp4[r]);
      end
      w5 <= wacc;
      s5 <= sacc;
    end
  end

  // Restoring divider, one quotient bit per stage: (2S + W) / (2W).
  always_ff @(posedge clk) begin
    logic [NW-1:0] sh;
    logic [QW-1:0] qn;
    if (adv) begin
      drem[0] <= (NW'(s5) << 1) + NW'(w5);
      dden[0] <= NW'(w5) << 1;
      dq[0]   <= '0;
      dz[0]   <= (w5 == '0);
      for (int j = 0; j < QW; j++) begin
        sh          = dden[j] << (QW - 1 - j);
        qn          = dq[j];
        dden[j+1]   <= dden[j];
        dz[j+1]     <= dz[j];
        if (drem[j] >= sh) begin
          drem[j+1]      <= drem[j] - sh;
          qn[QW - 1 - j] = 1'b1;
        end else begin
          drem[j+1]      <= drem[j];
        end
        dq[j+1]     <= qn;
      end
    end
  end

  // An empty rule set always reports a zero angle.
  `FTSC_ASSERT_NOW(a_no_fire_zero, m_tvalid && m_tuser, m_tdata == 8'd0)
  // A fired rule set never averages beyond the highest centroid.
  `FTSC_ASSERT_NOW(a_angle_range, m_tvalid && !m_tuser, m_tdata <= 8'd135)
  // Reset empties the pipeline.
  `FTSC_ASSERT_NEXT(a_reset_empty, rst, !m_tvalid)

endmodule

// ===== bench/ftsc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fuzzy servo controller checker
// Watches the sample, angle and rule table channels, predicts each angle word
// from the accepted sample words and compares them in order.
// ---------------------------------------------------------------------------
module ftsc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [17:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          angles_seen,
  output int          idle_angles
);

  typedef struct packed {
    logic [7:0] angle;
    logic       idle;
  } angle_t;

  localparam int GF = ftsc_pkg::FRAC;

  angle_t      angle_q[$];
  logic [17:0] rules;

  function automatic longint unsigned membership(int x, int a, int b, int c);
    if (x <= a || x >= c) return 0;
    if (x <= b) return (longint'(x - a) << GF) / (b - a);
    return (longint'(c - x) << GF) / (c - b);
  endfunction

  function automatic angle_t servo_angle_of(logic [23:0] w, logic [17:0] tbl);
    int                t;
    int                h;
    longint unsigned   gt[3];
    longint unsigned   gh[3];
    longint unsigned   s;
    longint unsigned   acc;
    longint unsigned   wsum;
    longint unsigned   cen;
    angle_t            r;
    t = $signed(w[10:0]);
    h = w[20:11];
    gt[0] = membership(t, -200, 0, 200);
    gt[1] = membership(t, 100, 250, 400);
    gt[2] = membership(t, 300, 500, 700);
    gh[0] = membership(h, 0, 300, 600);
    gh[1] = membership(h, 400, 600, 800);
    gh[2] = membership(h, 700, 900, 1000);
    acc = 0;
    wsum = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s = gt[i] < gh[j] ? gt[i] : gh[j];
        case (tbl[2*(i*3+j) +: 2])
          2'd0: cen = 45;
          2'd1: cen = 90;
          default: cen = 135;
        endcase
        acc += s * cen;
        wsum += s;
      end
    end
    if (wsum == 0) begin
      r.angle = '0;
      r.idle = 1'b1;
    end else begin
      r.angle = 8'((2 * acc + wsum) / (2 * wsum));
      r.idle = 1'b0;
    end
    return r;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    angles_seen = 0;
    idle_angles = 0;
  end

  assign pending = angle_q.size();

  always @(posedge clk) begin
    angle_t got;
    angle_t want;
    if (rst) begin
      rules <= ftsc_pkg::RULE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) rules <= cfg_data;
      if (s_tvalid && s_tready) angle_q.push_back(servo_angle_of(s_tdata, rules));
      if (m_tvalid && m_tready) begin
        got.angle = m_tdata;
        got.idle = m_tuser;
        angles_seen++;
        if (got.idle) idle_angles++;
        if (angle_q.size() == 0) begin
          report("angle word with no sample pending");
        end else begin
          want = angle_q.pop_front();
          if (got.angle !== want.angle)
            report($sformatf("servo_angle got %0d want %0d", got.angle, want.angle));
          if (got.idle !== want.idle)
            report($sformatf("no_rule_fired got %0b want %0b", got.idle, want.idle));
        end
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fuzzy servo controller testbench
// Drives sample words under several rule tables with random gaps and output
// stalls, one long stall among them, and lets the checker judge every angle.
// ---------------------------------------------------------------------------
module tb;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // [10:0] temperature, [20:11] humidity
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;    // [7:0] servo_angle
  logic        m_tuser;    // [0] no_rule_fired
  logic        cfg_valid;
  logic        cfg_ready;
  logic [17:0] cfg_data;
  int          fail_count;
  int          pending;
  int          angles_seen;
  int          idle_angles;
  logic        hold_off;

  fuzzy_two_input_servo_controller u_top (.*);

  ftsc_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Send one sample word after a random gap and wait for it to be taken.
  task automatic send_sample(int t, int h);
    repeat ($urandom_range(0, 6)) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b0, 10'(h), 11'(t)};
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 1'b0;
  endtask

  // The checker queue drains, then the pipeline depth passes before a write.
  task automatic write_rules(logic [17:0] v);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly inside the term ranges, some across the whole field width.
  task automatic random_samples(int n);
    int t;
    int h;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        t = $urandom_range(0, 1000) - 300;
        h = $urandom_range(0, 1023);
      end else begin
        t = $urandom_range(0, 2047) - 1024;
        h = $urandom_range(0, 1023);
      end
      send_sample(t, h);
    end
  endtask

  // Receiver: a random wait before each word, plus one long hold-off asked
  // for by the stimulus.
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    int temps[] = '{-1024, -201, -200, -199, 0, 100, 175, 250, 350, 500,
                    699, 700, 1000, 1023};
    int hums[] = '{0, 1, 300, 450, 600, 750, 900, 999, 1000, 1001, 1023};
    logic [17:0] tables[] = '{18'h00000, 18'h3FFFF, 18'h15555, 18'h2AAAA,
                              18'h1B6DB};
    rst = 1'b1;
    hold_off = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Feet, peaks, humidity at and past full scale, field extremes.
    foreach (temps[i]) send_sample(temps[i], hums[i % hums.size()]);
    foreach (hums[i]) send_sample(250 + 50 * i, hums[i]);

    // Keep offering words while the output side holds off, so the block fills.
    hold_off = 1'b1;
    for (int k = 0; k < 40; k++) begin
      s_tvalid <= 1'b1;
      s_tdata <= {3'b0, 10'($urandom_range(0, 1000)), 11'($urandom_range(0, 800) - 200)};
      do @(posedge clk); while (!s_tready);
    end
    s_tvalid <= 1'b0;
    random_samples(200);

    foreach (tables[i]) begin
      write_rules(tables[i]);
      random_samples(170);
    end
    write_rules(18'($urandom_range(0, 262143)));
    random_samples(200);

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Covered %0d angle words, %0d with no rule fired, over seven rule tables.",
             angles_seen, idle_angles);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
